// File: design/ptpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpd_pkg
// Types and constants shared by the periodic task priority dispatcher.
// ----------------------------------------------------------------------------
package ptpd_pkg;

    localparam int TIME_W      = 32;
    localparam int TASK_W      = 6;
    localparam int RUNS_W      = 8;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int CNT_W_MAX   = 7;
    localparam int MAX_RESULTS = 16;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 2'd0,
        KIND_INSTALL = 2'd1,
        KIND_REMOVE  = 2'd2,
        KIND_UNUSED  = 2'd3
    } req_kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_INVALID   = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_RESERVED  = 2'd3
    } status_t;

    typedef enum logic {
        RES_STATUS   = 1'b0,
        RES_DISPATCH = 1'b1
    } res_kind_t;

    // One timer slot; first_due holds period plus first offset
    typedef struct packed {
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] first_due;
        logic              first_pending;
        logic              counted;
        logic [RUNS_W-1:0] runs_left;
        logic [TIME_W-1:0] total;
    } slot_rec_t;

    typedef struct packed {
        logic hit;
        logic freed;
    } slot_eval_t;

endpackage

// File: design/ptpd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpd_req_if
// Request channel: tick, install and remove items.
// ----------------------------------------------------------------------------
interface ptpd_req_if;

    logic                         valid;
    logic                         ready;
    logic [ptpd_pkg::KIND_W-1:0]  kind;
    logic [ptpd_pkg::TIME_W-1:0]  now_time;
    logic [ptpd_pkg::TASK_W-1:0]  task_prio;
    logic [ptpd_pkg::TIME_W-1:0]  period;
    logic [ptpd_pkg::TIME_W-1:0]  first_offset;
    logic                         counted_mode;
    logic [ptpd_pkg::RUNS_W-1:0]  run_times;

    modport source (
        output valid, kind, now_time, task_prio, period, first_offset,
               counted_mode, run_times,
        input  ready
    );

    modport sink (
        input  valid, kind, now_time, task_prio, period, first_offset,
               counted_mode, run_times,
        output ready
    );

endinterface

// File: design/ptpd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpd_rsp_if
// Result channel: status and dispatch results.
// ----------------------------------------------------------------------------
interface ptpd_rsp_if;

    logic                          valid;
    logic                          ready;
    logic                          result_kind;
    logic [ptpd_pkg::STATUS_W-1:0] status;
    logic [ptpd_pkg::TASK_W-1:0]   task_id;
    logic [ptpd_pkg::TIME_W-1:0]   run_total;
    logic                          last;

    modport source (
        output valid, result_kind, status, task_id, run_total, last,
        input  ready
    );

    modport sink (
        input  valid, result_kind, status, task_id, run_total, last,
        output ready
    );

endinterface

// File: design/periodic_task_priority_dispatcher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_priority_dispatcher_unit
// Timer slot per task priority; ticks dispatch due tasks in priority order.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  req      in   valid/ready    kind, now_time, task_prio, period,
//                               first_offset, counted_mode, run_times
//  rsp      out  valid/ready    result_kind, status, task_id, run_total, last
//
//  Install and remove: accept, then a status transfer.
//  A tick reads one slot record from the slot RAM per cycle while the scan
//  is not stalled, writes it back on a dispatch, then the final result leaves.
//  Each result waits in an output register; a full register stalls the scan on a hit.
//  Reset clears the used bits, the install count and the control state.
// ----------------------------------------------------------------------------
module periodic_task_priority_dispatcher_unit #(
    parameter int SLOTS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    ptpd_req_if.sink   req,
    ptpd_rsp_if.source rsp
);
    import ptpd_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int REC_W = $bits(slot_rec_t);
    localparam logic [CNT_W_MAX-1:0] SLOT_LIMIT = CNT_W_MAX'(SLOTS);
    localparam logic [IDX_W-1:0]     LAST_IDX   = IDX_W'(SLOTS - 1);
    localparam logic [RES_CNT_W-1:0] LAST_RES   = RES_CNT_W'(MAX_RESULTS - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_INST = 6'b000010,
        S_REM  = 6'b000100,
        S_TRD  = 6'b001000,
        S_TEV  = 6'b010000,
        S_TFL  = 6'b100000
    } state_t;

    state_t                 state_reg, state_next;
    logic [SLOTS-1:0]       used_reg, used_next;
    logic [CNT_W_MAX-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]       scan_reg, scan_next;
    logic [RES_CNT_W-1:0]   nres_reg, nres_next;
    logic                   cand_valid_reg, cand_valid_next;
    logic [IDX_W-1:0]       cand_id_reg, cand_id_next;
    logic [TIME_W-1:0]      cand_total_reg, cand_total_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_kind_reg, out_kind_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [TASK_W-1:0]      out_id_reg, out_id_next;
    logic [TIME_W-1:0]      out_total_reg, out_total_next;
    logic                   out_last_reg, out_last_next;

    logic [TIME_W-1:0]      now_reg;
    logic [TASK_W-1:0]      prio_reg;
    logic [TIME_W-1:0]      period_reg;
    logic [TIME_W-1:0]      offset_reg;
    logic                   counted_reg;
    logic [RUNS_W-1:0]      runs_reg;

    logic                   req_fire;
    logic                   out_free;
    logic [IDX_W-1:0]       prio_idx;
    logic                   prio_bad;
    logic                   inst_bad;
    logic                   stall;
    logic                   done;

    logic                   ram_wr_en;
    logic [IDX_W-1:0]       ram_wr_addr;
    slot_rec_t              ram_wr_rec;
    logic                   ram_rd_en;
    logic [IDX_W-1:0]       ram_rd_addr;
    logic [REC_W-1:0]       ram_rd_data;
    slot_rec_t              rd_rec;
    slot_rec_t              ev_rec;
    slot_eval_t             ev_res;
    slot_rec_t              new_rec;

    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign prio_idx  = prio_reg[IDX_W-1:0];
    assign prio_bad  = ({1'b0, prio_reg} >= SLOT_LIMIT);
    assign inst_bad  = prio_bad || (period_reg == '0) || (counted_reg && (runs_reg == '0))
                       || used_reg[prio_idx];
    assign rd_rec    = slot_rec_t'(ram_rd_data);

    always_comb
    begin
        new_rec               = '0;
        new_rec.start_time    = now_reg;
        new_rec.period        = period_reg;
        new_rec.first_due     = period_reg + offset_reg;
        new_rec.first_pending = 1'b1;
        new_rec.counted       = counted_reg;
        new_rec.runs_left     = runs_reg;
        new_rec.total         = '0;
    end

    ptpd_ram #(
        .WIDTH (REC_W),
        .DEPTH (SLOTS),
        .AW    (IDX_W)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (REC_W'(ram_wr_rec)),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    ptpd_eval u_eval (
        .rec      (rd_rec),
        .used     (used_reg[scan_reg]),
        .now_time (now_reg),
        .rec_new  (ev_rec),
        .res      (ev_res)
    );

    assign stall = ev_res.hit && cand_valid_reg && !out_free;
    assign done  = (scan_reg == LAST_IDX) || (ev_res.hit && (nres_reg == LAST_RES));

    always_comb
    begin
        state_next      = state_reg;
        used_next       = used_reg;
        count_next      = count_reg;
        scan_next       = scan_reg;
        nres_next       = nres_reg;
        cand_valid_next = cand_valid_reg;
        cand_id_next    = cand_id_reg;
        cand_total_next = cand_total_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_kind_next   = out_kind_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_total_next  = out_total_reg;
        out_last_next   = out_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = scan_reg;
        ram_wr_rec      = ev_rec;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = scan_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (req_kind_t'(req.kind))
                        KIND_TICK:
                        begin
                            state_next = S_TRD;
                            scan_next  = '0;
                            nres_next  = '0;
                        end
                        KIND_INSTALL: state_next = S_INST;
                        KIND_REMOVE:  state_next = S_REM;
                        default:      state_next = S_IDLE;
                    endcase
                end
            end
            S_INST:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = RES_STATUS;
                    out_id_next     = prio_reg;
                    out_total_next  = '0;
                    out_last_next   = 1'b1;
                    if (inst_bad)
                    begin
                        out_status_next = STATUS_INVALID;
                    end
                    else
                    begin
                        out_status_next     = STATUS_OK;
                        ram_wr_en           = 1'b1;
                        ram_wr_addr         = prio_idx;
                        ram_wr_rec          = new_rec;
                        used_next[prio_idx] = 1'b1;
                        count_next          = count_reg + CNT_W_MAX'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            S_REM:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = RES_STATUS;
                    out_id_next    = prio_reg;
                    out_total_next = '0;
                    out_last_next  = 1'b1;
                    priority if ((count_reg == '0) || prio_bad)
                    begin
                        out_status_next = STATUS_INVALID;
                    end
                    else if (!used_reg[prio_idx])
                    begin
                        out_status_next = STATUS_NOT_FOUND;
                    end
                    else
                    begin
                        out_status_next     = STATUS_OK;
                        used_next[prio_idx] = 1'b0;
                        count_next          = count_reg - CNT_W_MAX'(1);
                    end
                    state_next = S_IDLE;
                end
            end
            S_TRD:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_TEV;
            end
            S_TEV:
            begin
                if (!stall)
                begin
                    if (ev_res.hit)
                    begin
                        ram_wr_en = 1'b1;
                        if (ev_res.freed)
                        begin
                            used_next[scan_reg] = 1'b0;
                            if (count_reg != '0)
                            begin
                                count_next = count_reg - CNT_W_MAX'(1);
                            end
                        end
                        if (cand_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = RES_DISPATCH;
                            out_status_next = STATUS_OK;
                            out_id_next     = TASK_W'(cand_id_reg);
                            out_total_next  = cand_total_reg;
                            out_last_next   = 1'b0;
                        end
                        cand_valid_next = 1'b1;
                        cand_id_next    = scan_reg;
                        cand_total_next = ev_rec.total;
                        nres_next       = nres_reg + RES_CNT_W'(1);
                    end
                    if (done)
                    begin
                        state_next = S_TFL;
                    end
                    else
                    begin
                        scan_next   = scan_reg + IDX_W'(1);
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = scan_reg + IDX_W'(1);
                    end
                end
            end
            S_TFL:
            begin
                if (!cand_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = RES_DISPATCH;
                    out_status_next = STATUS_OK;
                    out_id_next     = TASK_W'(cand_id_reg);
                    out_total_next  = cand_total_reg;
                    out_last_next   = 1'b1;
                    cand_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            used_reg       <= '0;
            count_reg      <= '0;
            scan_reg       <= '0;
            nres_reg       <= '0;
            cand_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_reg       <= used_next;
            count_reg      <= count_next;
            scan_reg       <= scan_next;
            nres_reg       <= nres_next;
            cand_valid_reg <= cand_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_id_reg    <= cand_id_next;
        cand_total_reg <= cand_total_next;
        out_kind_reg   <= out_kind_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_total_reg  <= out_total_next;
        out_last_reg   <= out_last_next;
        if (req_fire)
        begin
            now_reg     <= req.now_time;
            prio_reg    <= req.task_prio;
            period_reg  <= req.period;
            offset_reg  <= req.first_offset;
            counted_reg <= req.counted_mode;
            runs_reg    <= req.run_times;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_kind = out_kind_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.task_id     = out_id_reg;
    assign rsp.run_total   = out_total_reg;
    assign rsp.last        = out_last_reg;

endmodule

// File: design/ptpd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ptpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/ptpd_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptpd_eval
// Expiry check and update of one timer slot against the tick time.
// ----------------------------------------------------------------------------
module ptpd_eval (
    input  ptpd_pkg::slot_rec_t               rec,
    input  logic                              used,
    input  logic [ptpd_pkg::TIME_W-1:0]       now_time,
    output ptpd_pkg::slot_rec_t               rec_new,
    output ptpd_pkg::slot_eval_t              res
);
    import ptpd_pkg::*;

    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] due;
    logic [RUNS_W-1:0] runs_dec;

    assign elapsed  = now_time - rec.start_time;
    assign due      = rec.first_pending ? rec.first_due : rec.period;
    assign runs_dec = rec.runs_left - RUNS_W'(1);

    always_comb
    begin
        rec_new               = rec;
        rec_new.start_time    = now_time;
        rec_new.first_pending = 1'b0;
        rec_new.total         = rec.total + TIME_W'(1);
        rec_new.runs_left     = rec.counted ? runs_dec : rec.runs_left;
        res.hit               = used && (elapsed >= due);
        res.freed             = rec.counted && (runs_dec == '0);
    end

endmodule
